@@ rtl/ptbl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptbl_pkg
// shared types, codes and field layout for the per-entry token bucket limiter
// ----------------------------------------------------------------------------
package ptbl_pkg;

  // field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int TIME_W   = 32;
  localparam int REQ_W    = 20;
  localparam int RATE_W   = 20;
  localparam int STATUS_W = 2;
  localparam int BAL_W    = 48;
  localparam int PROD_W   = TIME_W + RATE_W;
  localparam int SUM_W    = PROD_W + 2;

  // input tdata layout, lowest bit first
  localparam int IDX_LO   = 0;
  localparam int NOW_LO   = IDX_LO + IDX_W;
  localparam int REQ_LO   = NOW_LO + TIME_W;
  localparam int OD_LO    = REQ_LO + REQ_W;
  localparam int RCAP_LO  = OD_LO + 1;
  localparam int WCAP_LO  = RCAP_LO + RATE_W;
  localparam int IN_USED_W = WCAP_LO + RATE_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // defaults
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam logic [RATE_W-1:0] OD_RATE_RESET = RATE_W'(40000);
  localparam logic [TIME_W-1:0] BURST_MS_FACTOR = TIME_W'(300000);

  // command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_THROTTLED = 2'd2;

  // classified command handed from front end to back end
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic [TIME_W-1:0] now_ms;
    logic [REQ_W-1:0]  req;
    logic [RATE_W-1:0] rd_rate;
    logic [RATE_W-1:0] wr_rate;
  } cmd_t;

endpackage

@@ rtl/ptbl_front.sv @@
// ----------------------------------------------------------------------------
// ptbl_front
// accepts input transactions, classifies them and queues commands
// ----------------------------------------------------------------------------
module ptbl_front import ptbl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RATE_W-1:0]     cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic [RATE_W-1:0]  on_demand_rate;
  cmd_t               q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;
  logic               od;
  logic [IDX_W-1:0]   idx;
  cmd_t               cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_demand_rate <= OD_RATE_RESET;
    end else if (cfg_we) begin
      on_demand_rate <= cfg_wdata;
    end
  end

  // classify: range check and bucket rate selection
  assign idx = s_axis_tdata[IDX_LO +: IDX_W];
  assign od  = s_axis_tdata[OD_LO];

  always_comb begin
    cls.op       = s_axis_tuser;
    cls.idx      = idx;
    cls.in_range = (32'(idx) < 32'(TABLE_ENTRIES));
    cls.now_ms   = s_axis_tdata[NOW_LO +: TIME_W];
    cls.req      = s_axis_tdata[REQ_LO +: REQ_W];
    cls.rd_rate  = od ? on_demand_rate : s_axis_tdata[RCAP_LO +: RATE_W];
    cls.wr_rate  = od ? on_demand_rate : s_axis_tdata[WCAP_LO +: RATE_W];
  end

  assign s_axis_tready = (count != Q_CNT_W'(Q_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (count != '0);
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

endmodule

@@ rtl/ptbl_back.sv @@
// ----------------------------------------------------------------------------
// ptbl_back
// executes commands: table read-modify-write, refill, debit, result register
// ----------------------------------------------------------------------------
module ptbl_back import ptbl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [BAL_W-1:0]    out_balance
);

  localparam int DEPTH = (TABLE_ENTRIES < (1 << IDX_W)) ? TABLE_ENTRIES : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FETCH    = 4'd1;
  localparam logic [3:0] S_MUL      = 4'd2;
  localparam logic [3:0] S_LIM      = 4'd3;
  localparam logic [3:0] S_CAP      = 4'd4;
  localparam logic [3:0] S_DEBIT    = 4'd5;
  localparam logic [3:0] S_REG_R    = 4'd6;
  localparam logic [3:0] S_REG_W    = 4'd7;
  localparam logic [3:0] S_REG_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // table storage
  logic              entry_valid [DEPTH];
  logic [BAL_W-1:0]  bal_r  [DEPTH];
  logic [BAL_W-1:0]  bal_w  [DEPTH];
  logic [TIME_W-1:0] last_r [DEPTH];
  logic [TIME_W-1:0] last_w [DEPTH];
  logic [RATE_W-1:0] rate_r [DEPTH];
  logic [RATE_W-1:0] rate_w [DEPTH];

  // datapath registers
  cmd_t                    cur;
  logic [BAL_W-1:0]        row_bal;
  logic [TIME_W-1:0]       row_last;
  logic [RATE_W-1:0]       row_rate;
  logic [PROD_W-1:0]       prod;
  logic                    refill;
  logic signed [SUM_W-1:0] sum;
  logic [BAL_W-1:0]        prior;
  logic [BAL_W-1:0]        lim;

  logic [AW-1:0]           cmd_addr;
  logic [AW-1:0]           cur_addr;
  logic                    cur_is_wr;
  logic                    take;
  logic                    is_req;
  logic                    hit;
  logic [TIME_W-1:0]       elapsed;
  logic [TIME_W-1:0]       mul_a;
  logic [RATE_W-1:0]       mul_b;
  logic signed [SUM_W-1:0] lim_ext;
  logic signed [BAL_W:0]   diff;
  logic [BAL_W-1:0]        bal_next;
  logic                    out_set;
  logic [STATUS_W-1:0]     status_next;
  logic [BAL_W-1:0]        balance_next;

  assign cmd_addr  = cmd.idx[AW-1:0];
  assign cur_addr  = cur.idx[AW-1:0];
  assign cur_is_wr = (cur.op == OP_WRITE);
  assign cmd_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take      = cmd_valid && cmd_ready;
  assign is_req    = (cmd.op == OP_READ) || (cmd.op == OP_WRITE);
  assign hit       = cmd.in_range && entry_valid[cmd_addr];
  assign elapsed   = cur.now_ms - row_last;
  assign lim_ext   = $signed({2'b00, prod});

  // debit with debt floor
  assign diff     = $signed({prior[BAL_W-1], prior}) - $signed({{(BAL_W+1-REQ_W){1'b0}}, cur.req});
  assign bal_next = (diff[BAL_W] && !diff[BAL_W-1]) ? {1'b1, {(BAL_W-1){1'b0}}} : diff[BAL_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (cmd.op == OP_REGISTER && cmd.in_range) state_next = S_REG_R;
          else if (is_req && hit) state_next = S_FETCH;
        end
      end
      S_FETCH:    state_next = S_MUL;
      S_MUL:      state_next = S_LIM;
      S_LIM:      state_next = S_CAP;
      S_CAP:      state_next = S_DEBIT;
      S_DEBIT:    state_next = S_IDLE;
      S_REG_R:    state_next = S_REG_W;
      S_REG_W:    state_next = S_REG_DONE;
      S_REG_DONE: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    out_set      = 1'b0;
    status_next  = STATUS_OK;
    balance_next = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_REMOVE: out_set = 1'b1;
            OP_REGISTER: begin
              out_set     = !cmd.in_range;
              status_next = STATUS_NOT_FOUND;
            end
            default: begin
              out_set     = !hit;
              status_next = STATUS_NOT_FOUND;
            end
          endcase
        end
      end
      S_DEBIT: begin
        out_set      = 1'b1;
        status_next  = prior[BAL_W-1] ? STATUS_THROTTLED : STATUS_OK;
        balance_next = bal_next;
      end
      S_REG_DONE: begin
        out_set      = 1'b1;
        balance_next = lim;
      end
      default: out_set = 1'b0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = BURST_MS_FACTOR;
    mul_b = row_rate;
    case (state)
      S_MUL:   mul_a = elapsed;
      S_REG_R: mul_b = cur.rd_rate;
      S_REG_W: mul_b = cur.wr_rate;
      default: mul_b = row_rate;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < DEPTH; i++) entry_valid[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (out_set) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (take && cmd.op == OP_REMOVE && cmd.in_range) entry_valid[cmd_addr] <= 1'b0;
      if (state == S_REG_DONE) entry_valid[cur_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= cmd;
    if (out_set) begin
      out_status  <= status_next;
      out_balance <= balance_next;
    end
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (state == S_MUL) refill <= (elapsed != '0) && (row_rate != '0);
    if (state == S_LIM) sum <= $signed({{(SUM_W-BAL_W){row_bal[BAL_W-1]}}, row_bal})
                             + $signed({2'b00, prod});
    if (state == S_CAP) begin
      if (!refill) prior <= row_bal;
      else if (sum < lim_ext) prior <= sum[BAL_W-1:0];
      else prior <= prod[BAL_W-1:0];
    end
    if (state == S_REG_W) lim <= prod[BAL_W-1:0];
  end

  // table read and write-back
  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      if (cur_is_wr) begin
        row_bal  <= bal_w[cur_addr];
        row_last <= last_w[cur_addr];
        row_rate <= rate_w[cur_addr];
      end else begin
        row_bal  <= bal_r[cur_addr];
        row_last <= last_r[cur_addr];
        row_rate <= rate_r[cur_addr];
      end
    end
    if (state == S_REG_W) begin
      bal_r[cur_addr]  <= prod[BAL_W-1:0];
      last_r[cur_addr] <= cur.now_ms;
      rate_r[cur_addr] <= cur.rd_rate;
    end
    if (state == S_REG_DONE) begin
      bal_w[cur_addr]  <= prod[BAL_W-1:0];
      last_w[cur_addr] <= cur.now_ms;
      rate_w[cur_addr] <= cur.wr_rate;
    end
    if (state == S_DEBIT) begin
      if (cur_is_wr) begin
        bal_w[cur_addr] <= bal_next;
        if (refill) last_w[cur_addr] <= cur.now_ms;
      end else begin
        bal_r[cur_addr] <= bal_next;
        if (refill) last_r[cur_addr] <= cur.now_ms;
      end
    end
  end

endmodule

@@ rtl/per_table_token_bucket_limiter_top.sv @@
// ----------------------------------------------------------------------------
// per_table_token_bucket_limiter_top
// per-entry read/write token bucket rate limiter with a command table
// ----------------------------------------------------------------------------
// usage
//   input stream (s_axis_*): one transaction per command; tuser carries the
//   operation (register, remove, read request, write request), tdata the
//   entry index, the current time in ms, the request size and the register
//   arguments. output stream (m_axis_*): exactly one result transaction per
//   command, in order; tuser is the status, tdata the bucket balance.
//   cfg_we/cfg_wdata set the on-demand rate; write it only while idle.
// sequencing
//   commands pass a two-entry queue into a sequencer that owns the table and
//   one shared 32x20 multiplier. remove and not-found commands finish in
//   idle; register steps through read limit, write limit and done;
//   read/write requests step through fetch, elapsed product, limit product
//   and add, cap, debit and write-back. a new command is taken only in idle
//   with the result register free.
// reset
//   rst clears the queue, the result valid flag and all entry valid bits and
//   sets the on-demand rate to 40000; balances stay unset until registered.
// back-pressure
//   a stalled result holds in the output register; the queue keeps taking
//   commands until it holds two, then tready drops.
// ----------------------------------------------------------------------------
module per_table_token_bucket_limiter_top import ptbl_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: on-demand rate
  input  logic                  cfg_we,
  input  logic [RATE_W-1:0]     cfg_wdata,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // table_index, now_ms, request_milli_units, on_demand, read_capacity,
  // write_capacity, zero fill
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // operation
  input  logic [OP_W-1:0]       s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // balance
  output logic [BAL_W-1:0]      m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // front end: config register, classification, command queue
  ptbl_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  // back end: table sequencer and result register
  ptbl_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_balance(m_axis_tdata)
  );

endmodule

@@ rtl/ptbl_checker.sv @@
// ----------------------------------------------------------------------------
// ptbl_checker
// port-level assertions for the token bucket limiter, bound to the top level
// ----------------------------------------------------------------------------
module ptbl_checker import ptbl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [BAL_W-1:0]      m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // only defined status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_NOT_FOUND
      || m_axis_tuser == STATUS_THROTTLED))
    else $error("undefined status code");

  // not-found results carry a zero balance
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STATUS_NOT_FOUND |-> m_axis_tdata == '0)
    else $error("not-found result with nonzero balance");

  // a throttled request leaves the bucket in debt
  a_throttled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STATUS_THROTTLED |-> m_axis_tdata[BAL_W-1])
    else $error("throttled result with non-negative balance");

endmodule

bind per_table_token_bucket_limiter_top ptbl_checker u_ptbl_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

@@ test/per_table_token_bucket_limiter_top_tb.sv @@
// ----------------------------------------------------------------------------
// per_table_token_bucket_limiter_top_tb
// self-checking bench for the per-entry read/write token bucket limiter: a
// short table of hand-picked commands, then random register, remove and
// request traffic under several on-demand rates, every result compared with
// a bench-side bucket predictor while both streams idle at random
// ----------------------------------------------------------------------------
module per_table_token_bucket_limiter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptbl_pkg::*;

  localparam int ENTRIES = 16;
  localparam longint REFILL_WINDOW_MS = 300000;           // limit = rate * this
  localparam longint DEBT_FLOOR = -64'sd140737488355328;  // -2^47
  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [REQ_W-1:0] REQ_MAX = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int DRAIN_GUARD = 20000;
  localparam int MAX_PRINTS = 40;

  // one command as it travels on the input stream
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] now;
    logic [REQ_W-1:0]  req;
    logic              od;
    logic [RATE_W-1:0] rcap;
    logic [RATE_W-1:0] wcap;
  } limiter_cmd_t;

  // one result transaction
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BAL_W-1:0]    balance;
  } bucket_res_t;

  // directed row: fixed answer only where it is obvious
  typedef struct {
    limiter_cmd_t cmd;
    bit           fixed;
    bucket_res_t  res;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [RATE_W-1:0]     cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;   // idx, now_ms, req, on_demand, rcap, wcap, zero fill
  logic [OP_W-1:0]       s_axis_tuser;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [BAL_W-1:0]      m_axis_tdata;   // balance
  logic [STATUS_W-1:0]   m_axis_tuser;   // status

  // bench copy of the limiter state
  bit                e_valid   [ENTRIES];
  longint            e_rd_bal  [ENTRIES];
  longint            e_wr_bal  [ENTRIES];
  logic [TIME_W-1:0] e_rd_last [ENTRIES];
  logic [TIME_W-1:0] e_wr_last [ENTRIES];
  logic [RATE_W-1:0] e_rd_rate [ENTRIES];
  logic [RATE_W-1:0] e_wr_rate [ENTRIES];
  logic [RATE_W-1:0] od_rate = OD_RATE_RESET;

  bucket_res_t       pending_results[$];  // expected results, oldest first
  directed_row_t     directed_rows[$];
  int                mismatches = 0;
  bit                sender_quiet = 1'b0;
  bit                recv_quiet = 1'b0;
  logic [TIME_W-1:0] now_track = '0;      // running clock for random traffic

  per_table_token_bucket_limiter_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(string what);
    if (mismatches < MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // idle length: mostly none, some short, a few long; none in quiet stretches
  function automatic int idle_len(bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // random rate: small ones make buckets run dry, big ones stay full
  function automatic logic [RATE_W-1:0] random_rate();
    int r;
    r = $urandom_range(99);
    if (r < 30) return RATE_W'($urandom_range(20, 1));
    if (r < 45) return '0;
    if (r < 60) return RATE_MAX;
    return RATE_W'($urandom_range(2**RATE_W - 1));
  endfunction

  // bucket predictor: works out the result of one command and updates the
  // bench state; refill by elapsed ms times rate capped at the limit, then an
  // unconditional debit granted only when the balance before it was not
  // negative
  function automatic bucket_res_t predict_step(limiter_cmd_t c);
    bucket_res_t       r;
    logic [RATE_W-1:0] rate;
    logic [TIME_W-1:0] last;
    logic [TIME_W-1:0] elapsed;
    longint            bal;
    longint            add;
    longint            lim;
    longint            prior;
    r.status = STATUS_OK;
    r.balance = '0;
    case (c.op)
      OP_REGISTER: begin
        e_valid[c.idx] = 1'b1;
        e_rd_rate[c.idx] = c.od ? od_rate : c.rcap;
        e_wr_rate[c.idx] = c.od ? od_rate : c.wcap;
        e_rd_bal[c.idx] = longint'(e_rd_rate[c.idx]) * REFILL_WINDOW_MS;
        e_wr_bal[c.idx] = longint'(e_wr_rate[c.idx]) * REFILL_WINDOW_MS;
        e_rd_last[c.idx] = c.now;
        e_wr_last[c.idx] = c.now;
        bal = e_rd_bal[c.idx];
        r.balance = bal[BAL_W-1:0];
      end
      OP_REMOVE: begin
        e_valid[c.idx] = 1'b0;
      end
      default: begin
        if (!e_valid[c.idx]) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          if (c.op == OP_READ) begin
            bal = e_rd_bal[c.idx];
            last = e_rd_last[c.idx];
            rate = e_rd_rate[c.idx];
          end else begin
            bal = e_wr_bal[c.idx];
            last = e_wr_last[c.idx];
            rate = e_wr_rate[c.idx];
          end
          // elapsed wraps, so a clock that went back counts as a long gap
          elapsed = c.now - last;
          add = longint'(elapsed) * longint'(rate);
          if (elapsed != '0 && add > 0) begin
            lim = longint'(rate) * REFILL_WINDOW_MS;
            bal = (bal + add < lim) ? bal + add : lim;
            last = c.now;
          end
          prior = bal;
          bal = prior - longint'(c.req);
          if (bal < DEBT_FLOOR) bal = DEBT_FLOOR;
          r.status = (prior >= 0) ? STATUS_OK : STATUS_THROTTLED;
          r.balance = bal[BAL_W-1:0];
          if (c.op == OP_READ) begin
            e_rd_bal[c.idx] = bal;
            e_rd_last[c.idx] = last;
          end else begin
            e_wr_bal[c.idx] = bal;
            e_wr_last[c.idx] = last;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic limiter_cmd_t random_cmd();
    limiter_cmd_t c;
    int           r;
    r = $urandom_range(99);
    c.op = (r < 10) ? OP_REGISTER : (r < 13) ? OP_REMOVE : (r < 56) ? OP_READ : OP_WRITE;
    c.idx = IDX_W'($urandom_range(ENTRIES - 1));
    // time mostly creeps, sometimes jumps far, now and then steps back
    r = $urandom_range(99);
    if (r < 80) now_track += $urandom_range(3);
    else if (r < 92) now_track += $urandom_range(2000);
    else if (r < 96) now_track = $urandom;
    else now_track -= $urandom_range(50);
    c.now = now_track;
    r = $urandom_range(99);
    if (r < 35) c.req = REQ_W'($urandom_range(5000));
    else if (r < 45) c.req = REQ_MAX;
    else if (r < 55) c.req = '0;
    else c.req = REQ_W'($urandom_range(2**REQ_W - 1));
    c.od = 1'($urandom_range(1));
    c.rcap = random_rate();
    c.wcap = random_rate();
    return c;
  endfunction

  function automatic directed_row_t row(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                        logic [TIME_W-1:0] now, logic [REQ_W-1:0] req,
                                        logic od, logic [RATE_W-1:0] rcap,
                                        logic [RATE_W-1:0] wcap, bit fixed = 1'b0,
                                        logic [STATUS_W-1:0] status = STATUS_OK,
                                        logic [BAL_W-1:0] balance = '0);
    directed_row_t d;
    d.cmd.op = op;
    d.cmd.idx = idx;
    d.cmd.now = now;
    d.cmd.req = req;
    d.cmd.od = od;
    d.cmd.rcap = rcap;
    d.cmd.wcap = wcap;
    d.fixed = fixed;
    d.res.status = status;
    d.res.balance = balance;
    return d;
  endfunction

  // one input transaction: optional gap, hold valid until the handshake,
  // then record what the result should be
  task automatic send_cmd(limiter_cmd_t c, bit fixed, bucket_res_t fixed_res);
    int             gap;
    bucket_res_t    want;
    logic [IN_TDATA_W-1:0] d;
    gap = idle_len(sender_quiet);
    d = '0;
    d[IDX_LO +: IDX_W] = c.idx;
    d[NOW_LO +: TIME_W] = c.now;
    d[REQ_LO +: REQ_W] = c.req;
    d[OD_LO] = c.od;
    d[RCAP_LO +: RATE_W] = c.rcap;
    d[WCAP_LO +: RATE_W] = c.wcap;
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.op;
    s_axis_tdata <= d;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    // the predictor always runs so its state follows the block
    want = predict_step(c);
    pending_results.push_back(fixed ? fixed_res : want);
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic drain_results();
    int guard;
    guard = 0;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    // margin past the longest command latency
    repeat (10) @(posedge clk);
  endtask

  // on-demand rate is only written with the block idle
  task automatic set_od_rate(logic [RATE_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    od_rate = v;
  endtask

  // result checker: every result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    bucket_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d balance %h",
                                m_axis_tuser, m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          note_mismatch($sformatf("status %0d, wanted %0d", m_axis_tuser, want.status));
        if (m_axis_tdata !== want.balance)
          note_mismatch($sformatf("balance %h, wanted %h", m_axis_tdata, want.balance));
      end
    end
  end

  // result side back-pressure
  initial begin : result_stalls
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(199) == 0) recv_quiet = !recv_quiet;
      if (stall == 0) stall = idle_len(recv_quiet);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    bucket_res_t  none;
    logic [RATE_W-1:0] phase_rate [4];
    none.status = STATUS_OK;
    none.balance = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_REGISTER;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // requests to empty entries, then extremes of rates, sizes and time
    directed_rows.push_back(row(OP_READ, 0, 0, 0, 0, 0, 0, 1, STATUS_NOT_FOUND, 0));
    directed_rows.push_back(row(OP_WRITE, 15, 0, REQ_MAX, 0, 0, 0, 1, STATUS_NOT_FOUND, 0));
    directed_rows.push_back(row(OP_REMOVE, 3, 0, 0, 0, 0, 0, 1, STATUS_OK, 0));
    // full-rate read bucket, zero-rate write bucket
    directed_rows.push_back(row(OP_REGISTER, 0, 0, 0, 0, RATE_MAX, 0, 1, STATUS_OK,
                                48'd314572500000));
    directed_rows.push_back(row(OP_READ, 0, 0, REQ_MAX, 0, 0, 0));
    directed_rows.push_back(row(OP_WRITE, 0, 0, REQ_MAX, 0, 0, 0));
    // zero-rate write bucket never refills: stays in debt and is throttled; then a read
    directed_rows.push_back(row(OP_WRITE, 0, 1000, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, 0, 1000, 0, 0, 0, 0));
    // on-demand entry at the reset rate, stamped at the top of the clock
    directed_rows.push_back(row(OP_REGISTER, 15, TIME_MAX, 0, 1, 0, RATE_MAX, 1, STATUS_OK,
                                48'd12000000000));
    // clock wraps to zero, then steps back a little (long interval)
    directed_rows.push_back(row(OP_WRITE, 15, 0, REQ_MAX, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, 15, TIME_MAX - 1, 5, 0, 0, 0));
    // tiny buckets: drain into debt, throttle, refill by a single ms
    directed_rows.push_back(row(OP_REGISTER, 7, 100, 0, 0, 1, 1, 1, STATUS_OK, 48'd300000));
    directed_rows.push_back(row(OP_READ, 7, 100, REQ_MAX, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, 7, 100, REQ_MAX, 0, 0, 0));
    directed_rows.push_back(row(OP_READ, 7, 101, 0, 0, 0, 0));
    // drain exactly to zero, then a zero balance still grants
    directed_rows.push_back(row(OP_WRITE, 7, 100, 300000, 0, 0, 0));
    directed_rows.push_back(row(OP_WRITE, 7, 100, 1, 0, 0, 0));
    // re-register reinitializes, remove twice, request after remove
    directed_rows.push_back(row(OP_REGISTER, 7, 200, 0, 0, 2, RATE_MAX, 1, STATUS_OK,
                                48'd600000));
    directed_rows.push_back(row(OP_REMOVE, 7, 0, 0, 0, 0, 0, 1, STATUS_OK, 0));
    directed_rows.push_back(row(OP_READ, 7, 200, 0, 0, 0, 0, 1, STATUS_NOT_FOUND, 0));
    directed_rows.push_back(row(OP_REMOVE, 7, 0, 0, 0, 0, 0, 1, STATUS_OK, 0));
    directed_rows.push_back(row(OP_WRITE, 0, 5, 0, 0, 0, 0));
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].res);

    // random traffic under a few on-demand rates, extremes included; each
    // rate change drains the block first
    phase_rate[0] = RATE_MAX;
    phase_rate[1] = '0;
    phase_rate[2] = RATE_W'($urandom_range(2**RATE_W - 1));
    phase_rate[3] = 1;
    foreach (phase_rate[p]) begin
      set_od_rate(phase_rate[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(39) == 0) sender_quiet = !sender_quiet;
        // now and then hold off until the block has answered everything
        if ($urandom_range(199) == 0) drain_results();
        send_cmd(random_cmd(), 1'b0, none);
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ per_table_token_bucket_limiter_top.f @@
rtl/ptbl_pkg.sv
rtl/ptbl_front.sv
rtl/ptbl_back.sv
rtl/per_table_token_bucket_limiter_top.sv
rtl/ptbl_checker.sv
test/per_table_token_bucket_limiter_top_tb.sv
